// ===== sv/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// bca_pkg: shared types and constants for baro_compensate_and_average
// Widths, configuration register indexes, controller states and the command
// word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package bca_pkg;

    localparam int WINDOW_LENGTH = 10;
    localparam int PTR_W         = $clog2(WINDOW_LENGTH);

    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int NUM_COEFF = 6;
    localparam int CFG_IDX_W = 3;

    localparam int DT_W    = 25;   // dT = D2 - C5*256
    localparam int TD_W    = 18;   // TEMP - 2000
    localparam int T2_W    = 18;
    localparam int TEMP_W  = 20;   // final temperature in 0.01 C
    localparam int WIDE_W  = 40;   // OFF, SENS and their corrections
    localparam int MUL_W   = 26;   // signed operand width of the shared multiplier
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 64;
    localparam int PDIFF_W = 44;
    localparam int PRES_W  = 32;
    localparam int SUM_W   = 36;
    localparam int DEG_W   = 8;
    localparam int SPLIT   = 20;   // SENS is cut here into a low and a high part

    localparam int TEMP_REF    = 2000;
    localparam int TEMP_COLD2  = 3500;   // offset from TEMP_REF down to -15.00 C
    localparam int TEMP_SAT_HI = 12800;
    localparam int TEMP_SAT_LO = 12900;
    localparam int DEG_RECIP   = 5243;   // ceil(2^19 / 100), exact below 43690
    localparam int DEG_SHIFT   = 19;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_TEMP,
        ST_MUL_OFF,
        ST_MUL_SENS,
        ST_MUL_T2,
        ST_MUL_A,
        ST_MUL_B,
        ST_ADJUST,
        ST_MUL_PLO,
        ST_MUL_PHI,
        ST_ACCUM,
        ST_PRES,
        ST_PUBLISH
    } ctl_state_t;

    typedef enum logic [2:0] {
        MUL_DT_C6,
        MUL_C4_DT,
        MUL_C3_DT,
        MUL_DT_DT,
        MUL_SQ_A,
        MUL_SQ_B,
        MUL_D1_LO,
        MUL_D1_HI
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     ld_tdelta;
        logic     ld_off;
        logic     ld_sens;
        logic     ld_t2;
        logic     ld_corr;
        logic     ld_adjust;
        logic     ld_acc_lo;
        logic     ld_acc_hi;
        logic     ld_pres;
        logic     publish;
    } dp_cmd_t;

endpackage

// ===== sv/bca_ctrl.sv =====
// ----------------------------------------------------------------------------
// bca_ctrl: sequencer for the compensation datapath
// Steps one word through the multiply schedule and owns both handshakes.
// ----------------------------------------------------------------------------
module bca_ctrl
    import bca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_DT_C6;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_MUL_TEMP;
            end
            ST_MUL_TEMP:
            begin
                cmd.mul_sel = MUL_DT_C6;
                state_next  = ST_MUL_OFF;
            end
            ST_MUL_OFF:
            begin
                cmd.mul_sel   = MUL_C4_DT;
                cmd.ld_tdelta = 1'b1;
                state_next    = ST_MUL_SENS;
            end
            ST_MUL_SENS:
            begin
                cmd.mul_sel = MUL_C3_DT;
                cmd.ld_off  = 1'b1;
                state_next  = ST_MUL_T2;
            end
            ST_MUL_T2:
            begin
                cmd.mul_sel = MUL_DT_DT;
                cmd.ld_sens = 1'b1;
                state_next  = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.mul_sel = MUL_SQ_A;
                cmd.ld_t2   = 1'b1;
                state_next  = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_sel = MUL_SQ_B;
                cmd.ld_corr = 1'b1;
                state_next  = ST_ADJUST;
            end
            ST_ADJUST:
            begin
                cmd.ld_adjust = 1'b1;
                state_next    = ST_MUL_PLO;
            end
            ST_MUL_PLO:
            begin
                cmd.mul_sel = MUL_D1_LO;
                state_next  = ST_MUL_PHI;
            end
            ST_MUL_PHI:
            begin
                cmd.mul_sel   = MUL_D1_HI;
                cmd.ld_acc_lo = 1'b1;
                state_next    = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.ld_acc_hi = 1'b1;
                state_next    = ST_PRES;
            end
            ST_PRES:
            begin
                cmd.ld_pres = 1'b1;
                state_next  = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/bca_dpath.sv =====
// ----------------------------------------------------------------------------
// bca_dpath: compensation datapath
// Calibration registers, one shared signed multiplier, the intermediate
// registers, the pressure ring and the output registers.
// ----------------------------------------------------------------------------
module bca_dpath
    import bca_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COEFF_W-1:0]          cfg_data,
    input  logic [RAW_W-1:0]            raw_temperature,
    input  logic [RAW_W-1:0]            raw_pressure,
    output logic signed [DEG_W-1:0]     temperature_c,
    output logic signed [PRES_W-1:0]    pressure_pa,
    output logic signed [SUM_W-1:0]     pressure_window_sum
);

    logic [COEFF_W-1:0] coeff_reg [NUM_COEFF];

    logic signed [DT_W-1:0]    dt_reg;
    logic [RAW_W-1:0]          d1_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [TD_W-1:0]    tdelta_reg;
    logic [T2_W-1:0]           t2_reg;
    logic signed [WIDE_W-1:0]  off_reg, sens_reg, off2_reg, sens2_reg;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PRES_W-1:0]  pres_reg;
    logic signed [DEG_W-1:0]   deg_reg;
    logic signed [DEG_W-1:0]   temp_out_reg;
    logic signed [PRES_W-1:0]  pres_out_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [PRES_W-1:0]  ring_reg [WINDOW_LENGTH];
    logic [PTR_W-1:0]          ptr_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [TD_W:0]      tcold;
    logic                      cold, very_cold;
    logic signed [WIDE_W-1:0]  sq40, five_sq, seven_sq, eleven_half;
    logic signed [PDIFF_W-1:0] pdiff;
    logic                      tneg, sat_hi, sat_lo;
    logic [TEMP_W-1:0]         tmag;
    logic [26:0]               qprod;
    logic [DEG_W-1:0]          quot;
    logic signed [DEG_W-1:0]   deg_next;

    // calibration words; writes beyond the last index drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFF; i++)
                coeff_reg[i] <= '0;
        end
        else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_COEFF))
        begin
            coeff_reg[cfg_index] <= cfg_data;
        end
    end

    assign cold      = tdelta_reg[TD_W-1];
    assign very_cold = tdelta_reg < -TD_W'(TEMP_COLD2);
    assign tcold     = (TD_W+1)'(tdelta_reg) + (TD_W+1)'(TEMP_COLD2);

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DT_C6:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = $signed(MUL_W'(coeff_reg[CFG_C6]));
            end
            MUL_C4_DT:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = $signed(MUL_W'(coeff_reg[CFG_C4]));
            end
            MUL_C3_DT:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = $signed(MUL_W'(coeff_reg[CFG_C3]));
            end
            MUL_DT_DT:
            begin
                mul_a = MUL_W'(dt_reg);
                mul_b = MUL_W'(dt_reg);
            end
            MUL_SQ_A:
            begin
                mul_a = MUL_W'(tdelta_reg);
                mul_b = MUL_W'(tdelta_reg);
            end
            MUL_SQ_B:
            begin
                mul_a = MUL_W'(tcold);
                mul_b = MUL_W'(tcold);
            end
            MUL_D1_LO:
            begin
                mul_a = $signed(MUL_W'(d1_reg));
                mul_b = $signed(MUL_W'(sens_reg[SPLIT-1:0]));
            end
            MUL_D1_HI:
            begin
                mul_a = $signed(MUL_W'(d1_reg));
                mul_b = MUL_W'($signed(sens_reg[WIDE_W-1:SPLIT]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // squared terms for the low temperature corrections
    assign sq40        = WIDE_W'(prod_reg);
    assign five_sq     = sq40 + (sq40 <<< 2);
    assign seven_sq    = (sq40 <<< 3) - sq40;
    assign eleven_half = ((sq40 <<< 3) + (sq40 <<< 1) + sq40) >>> 1;

    assign pdiff = PDIFF_W'(acc_reg >>> 21) - PDIFF_W'(off_reg);

    // whole degrees: saturate, else divide the magnitude by 100
    assign tneg   = temp_reg[TEMP_W-1];
    assign tmag   = tneg ? TEMP_W'(-temp_reg) : TEMP_W'(temp_reg);
    assign sat_hi = !tneg && (temp_reg >= TEMP_W'(TEMP_SAT_HI));
    assign sat_lo = tneg && (tmag >= TEMP_W'(TEMP_SAT_LO));
    assign qprod  = 27'(tmag[13:0]) * 27'(DEG_RECIP);
    assign quot   = qprod[DEG_SHIFT +: DEG_W];

    always_comb
    begin
        if (sat_hi)
            deg_next = 8'sd127;
        else if (sat_lo)
            deg_next = -8'sd128;
        else if (tneg)
            deg_next = $signed(~quot + 8'd1);
        else
            deg_next = $signed(quot);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture)
        begin
            dt_reg <= $signed({1'b0, raw_temperature})
                    - $signed({1'b0, coeff_reg[CFG_C5], 8'd0});
            d1_reg <= raw_pressure;
        end
        if (cmd.ld_tdelta)
            tdelta_reg <= prod_reg[TD_W+22:23];
        if (cmd.ld_off)
            off_reg <= $signed(WIDE_W'({coeff_reg[CFG_C2], 16'd0}))
                     + WIDE_W'(prod_reg >>> 7);
        if (cmd.ld_sens)
            sens_reg <= $signed(WIDE_W'({coeff_reg[CFG_C1], 15'd0}))
                      + WIDE_W'(prod_reg >>> 8);
        if (cmd.ld_t2)
            t2_reg <= cold ? prod_reg[T2_W+30:31] : '0;
        if (cmd.ld_corr)
        begin
            off2_reg  <= cold ? (five_sq >>> 1) : '0;
            sens2_reg <= cold ? (five_sq >>> 2) : '0;
        end
        if (cmd.ld_adjust)
        begin
            off_reg  <= off_reg - off2_reg - (very_cold ? seven_sq : '0);
            sens_reg <= sens_reg - sens2_reg - (very_cold ? eleven_half : '0);
            temp_reg <= TEMP_W'(tdelta_reg) + TEMP_W'(TEMP_REF)
                      - $signed(TEMP_W'(t2_reg));
        end
        if (cmd.ld_acc_lo)
            acc_reg <= ACC_W'(prod_reg);
        if (cmd.ld_acc_hi)
            acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< SPLIT);
        if (cmd.ld_pres)
        begin
            pres_reg <= PRES_W'(pdiff >>> 15);
            deg_reg  <= deg_next;
        end
        if (cmd.publish)
        begin
            temp_out_reg <= deg_reg;
            pres_out_reg <= pres_reg;
        end
    end

    // pressure ring and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
                ring_reg[i] <= '0;
            ptr_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.publish)
        begin
            sum_reg <= sum_reg - SUM_W'(ring_reg[ptr_reg]) + SUM_W'(pres_reg);
            ring_reg[ptr_reg] <= pres_reg;
            if (ptr_reg == PTR_W'(WINDOW_LENGTH - 1))
                ptr_reg <= '0;
            else
                ptr_reg <= ptr_reg + PTR_W'(1);
        end
    end

    assign temperature_c       = temp_out_reg;
    assign pressure_pa         = pres_out_reg;
    assign pressure_window_sum = sum_reg;

endmodule

// ===== sv/baro_compensate_and_average.sv =====
// ----------------------------------------------------------------------------
// baro_compensate_and_average: barometric compensation with a pressure window
// Applies the six calibration words with second order correction below 20 C,
// reports whole degrees and pascal, and keeps a sum of the latest pressures.
// ----------------------------------------------------------------------------
//  channel   signals                                   word
//  input     in_valid / in_ready                       raw_temperature, raw_pressure
//  output    out_valid / out_ready                     temperature_c, pressure_pa,
//                                                      pressure_window_sum
//  config    cfg_we, cfg_index, cfg_data               one calibration word
//
//  A word passes through twelve steps of the controller from acceptance to
//  the output register, set by the eight products that share one
//  26x26 signed multiplier and the add steps between them. A new input word
//  is taken only in the idle step, once the word before it is published.
//  Reset clears the calibration words, the ring, its pointer and the sum.
//  A finished word waits in the output register; the next input word is taken
//  and worked on meanwhile, and only its final step holds until the output
//  register is free.
module baro_compensate_and_average
    import bca_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [RAW_W-1:0]          raw_temperature,
    input  logic [RAW_W-1:0]          raw_pressure,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DEG_W-1:0]   temperature_c,
    output logic signed [PRES_W-1:0]  pressure_pa,
    output logic signed [SUM_W-1:0]   pressure_window_sum,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COEFF_W-1:0]        cfg_data
);

    dp_cmd_t cmd;

    // sequencer: walks the multiply schedule and owns both handshakes
    bca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: coefficients, shared multiplier, ring and output registers
    bca_dpath u_dpath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .raw_temperature     (raw_temperature),
        .raw_pressure        (raw_pressure),
        .temperature_c       (temperature_c),
        .pressure_pa         (pressure_pa),
        .pressure_window_sum (pressure_window_sum)
    );

    // a published word shows up as valid in the next cycle
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid)
        else $error("published word not presented");

    // an accepted word keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input reopened during compensation");

    // publishing returns the sequencer to accept the next word
    a_publish_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> in_ready)
        else $error("input not reopened after publish");

    // at most one load step of the datapath per cycle
    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ld_tdelta, cmd.ld_off, cmd.ld_sens, cmd.ld_t2, cmd.ld_corr,
                  cmd.ld_adjust, cmd.ld_acc_lo, cmd.ld_acc_hi, cmd.ld_pres,
                  cmd.publish, cmd.capture}))
        else $error("overlapping datapath steps");

endmodule
